FILE: hw/rtl/rmss_pkg.sv
// Shared constants, types and state codes of the ray march segment scheduler.
`default_nettype none
package rmss_pkg;

	localparam int MAX_INTERVALS = 8;
	localparam int IDX_W         = $clog2(MAX_INTERVALS);
	localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
	localparam int DIST_W        = 32;
	localparam int SPC_W         = 31;
	localparam int SMP_W         = 16;
	localparam int TOT_W         = 36;
	localparam int DIV_W         = 44;
	localparam int DIV_CNT_W     = $clog2(DIV_W);
	localparam int CFG_IDX_W     = 2;

	localparam logic [SMP_W-1:0] SMP_MAX = '1;
	localparam logic [SPC_W-1:0] SPC_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_DIST = 2'd0,
		CFG_STEPS    = 2'd1,
		CFG_AMBIENT  = 2'd2
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INS,
		S_GRID,
		S_GRID_W,
		S_SX,
		S_SX_W,
		S_SY,
		S_SY_W,
		S_MERGE,
		S_AFTER,
		S_TOT,
		S_TOT_W,
		S_SEG,
		S_GC,
		S_GC_W,
		S_GS,
		S_GS_W,
		S_MED,
		S_MED_W,
		S_MS,
		S_MS_W,
		S_NEXT,
		S_EMIT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic signed [DIST_W-1:0] seg_start;
		logic [SPC_W-1:0]         spacing;
		logic [SMP_W-1:0]         samples;
		logic                     is_medium;
		logic                     empty;
	} res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rmss_if.sv
// Valid/ready channel interfaces for interval items and segment results.
`default_nettype none
interface rmss_in_if;
	import rmss_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DIST_W-1:0] entry_dist;
	logic signed [DIST_W-1:0] exit_dist;
	logic                     last_interval;

	modport source (output valid, entry_dist, exit_dist, last_interval, input ready);
	modport sink (input valid, entry_dist, exit_dist, last_interval, output ready);
endinterface

interface rmss_out_if;
	import rmss_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DIST_W-1:0] seg_start;
	logic [SPC_W-1:0]         seg_spacing;
	logic [SMP_W-1:0]         seg_samples;
	logic                     in_medium;
	logic                     empty_schedule;
	logic                     last_segment;

	modport source (output valid, seg_start, seg_spacing, seg_samples, in_medium,
		empty_schedule, last_segment, input ready);
	modport sink (input valid, seg_start, seg_spacing, seg_samples, in_medium,
		empty_schedule, last_segment, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rmss_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module rmss_div (
	input  logic               clk,
	input  logic               arst_n,
	input  rmss_pkg::div_req_t req,
	output rmss_pkg::div_rsp_t rsp
);
	import rmss_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dsr_q;
	logic [DIV_W:0]       shifted;
	logic [DIV_W:0]       diff;
	logic                 ge;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = ~diff[DIV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in from the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
		end
	end

	assign rsp = '{done: done_q, quot: quo_q, rem: rem_q};

endmodule
`default_nettype wire

FILE: hw/rtl/ray_march_segment_scheduler.sv
// Ray march segment scheduler: top level with sequencer, interval stores and output stage.
//
// Usage: the intv channel carries one medium interval per transaction (entry, exit,
// last_interval). Intervals with exit not after entry are dropped; up to eight are kept
// and held sorted by entry, the insert shifting each larger entry up by one place.
// The transaction flagged last_interval starts the schedule build: grid width, snapping
// (ambient mode), merging, covered total, then per merged span an optional gap segment
// and one medium segment, plus a closing gap in ambient mode. Every division runs on one
// shared bit-serial divider of 44 bits. A schedule divides for the grid width and the
// covered total, twice per loaded interval (snapping, ambient mode only), at most twice
// per merged span, and once per gap check and once per gap sent.
// Results leave on the seg channel, last_segment marking the final one; an empty
// schedule gives one transaction with empty_schedule set. intv.ready is high only
// while the block waits for an item. A stalled receiver holds the output register and
// one pending result; the sequencer waits, nothing is lost.
// Reset clears the control state and loads max_distance 0, step_count 1, ambient_mode 0.
// Configuration writes are taken any cycle but belong to idle periods.
`default_nettype none
module ray_march_segment_scheduler (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rmss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rmss_pkg::SPC_W-1:0]         cfg_data,
	rmss_in_if.sink                            intv,
	rmss_out_if.source                         seg
);
	import rmss_pkg::*;

	localparam logic signed [DIST_W+1:0] X_MIN = -34'sd2147483648;

	state_t state_q, state_d, ret_q, ret_d;

	// configuration
	logic [SPC_W-1:0] maxd_q;
	logic [SMP_W-1:0] steps_q;
	logic             amb_q;
	logic [SMP_W-1:0] n_eff;

	// sorted raw intervals and merged spans
	logic signed [DIST_W-1:0] ent_q [MAX_INTERVALS];
	logic signed [DIST_W-1:0] ext_q [MAX_INTERVALS];
	logic signed [DIST_W-1:0] mst_q [MAX_INTERVALS];
	logic signed [DIST_W-1:0] mex_q [MAX_INTERVALS];
	logic [CNT_W-1:0]         live_q, mc_q, i_q, mc_dec;
	logic [IDX_W-1:0]         j_q, rd_idx, m_idx;
	logic signed [DIST_W-1:0] ent_rd, ext_rd, mst_rd, mex_rd;

	logic signed [DIST_W-1:0] ins_x_q, ins_y_q;
	logic                     pend_last_q;
	logic [SPC_W-1:0]         grid_q, inside_q;
	logic signed [DIST_W-1:0] sx_q, sy_q, msx_q, msy_q, cursor_q, gfrom_q, gto_q;
	logic                     gfinal_q;
	logic [TOT_W-1:0]         total_q;
	logic [DIST_W:0]          len_q, gap_d, add_v;
	logic [SMP_W-1:0]         smp_q;

	res_t res_q, pend_q, out_q;
	logic pend_v_q, out_v_q, out_last_q, out_free;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                     acc, in_ok, ins_shift;
	logic [DIST_W-1:0]        x_mag, y_mag;
	logic signed [DIST_W+1:0] xe, ye, r34, g34, fx, fy;
	logic signed [DIST_W-1:0] sx_new, sy_new;
	logic                     rem_zero;
	logic                     mrg_keep, mrg_join, mrg_ext;
	logic                     gap_before, fin_gap;
	logic [DIV_W-1:0]         lx, ix, l1000, den, med_dvd;
	logic                     num_pos;
	logic [SMP_W-1:0]         smp_sat;
	logic [SPC_W-1:0]         spc_sat, inside_new;

	rmss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign n_eff    = (steps_q == '0) ? SMP_W'(1) : steps_q;
	assign acc      = intv.valid && intv.ready;
	assign in_ok    = (intv.exit_dist > intv.entry_dist) &&
	                  (live_q < CNT_W'(MAX_INTERVALS));
	assign out_free = !out_v_q || seg.ready;

	// one read port on each store
	assign mc_dec = mc_q - 1'b1;
	assign rd_idx = (state_q == S_INS) ? IDX_W'(j_q - 1'b1) : i_q[IDX_W-1:0];
	assign m_idx  = (state_q == S_MERGE) ? mc_dec[IDX_W-1:0] : i_q[IDX_W-1:0];
	assign ent_rd = ent_q[rd_idx];
	assign ext_rd = ext_q[rd_idx];
	assign mst_rd = mst_q[m_idx];
	assign mex_rd = mex_q[m_idx];

	assign ins_shift = (j_q != '0) && (ent_rd > ins_x_q);

	// grid snap: floor of entry and ceiling of exit come from the remainder alone
	assign x_mag    = ent_rd[DIST_W-1] ? DIST_W'(-ent_rd) : DIST_W'(ent_rd);
	assign y_mag    = ext_rd[DIST_W-1] ? DIST_W'(-ext_rd) : DIST_W'(ext_rd);
	assign xe       = {{2{ent_rd[DIST_W-1]}}, ent_rd};
	assign ye       = {{2{ext_rd[DIST_W-1]}}, ext_rd};
	assign r34      = $signed({3'b000, div_rsp.rem[SPC_W-1:0]});
	assign g34      = $signed({3'b000, grid_q});
	assign rem_zero = (div_rsp.rem[SPC_W-1:0] == '0);

	always_comb begin
		if (!ent_rd[DIST_W-1]) begin
			fx = xe - r34;
		end else if (rem_zero) begin
			fx = xe;
		end else begin
			fx = xe + r34 - g34;
		end
		if (ext_rd[DIST_W-1]) begin
			fy = ye + r34;
		end else if (rem_zero) begin
			fy = ye;
		end else begin
			fy = ye + g34 - r34;
		end
		sx_new = (fx < X_MIN) ? $signed({1'b1, {(DIST_W-1){1'b0}}}) : fx[DIST_W-1:0];
		sy_new = (fy > $signed({3'b000, maxd_q})) ? $signed({1'b0, maxd_q}) : fy[DIST_W-1:0];
	end

	assign mrg_keep = sy_q > sx_q;
	assign mrg_join = (mc_q != '0) && (sx_q <= mex_rd);
	assign mrg_ext  = sy_q > mex_rd;
	assign add_v    = mrg_join ? ({sy_q[DIST_W-1], sy_q} - {mex_rd[DIST_W-1], mex_rd}) :
	                             ({sy_q[DIST_W-1], sy_q} - {sx_q[DIST_W-1], sx_q});

	assign gap_before = amb_q && (mst_rd > cursor_q);
	assign fin_gap    = amb_q && ($signed({1'b0, maxd_q}) > msy_q);
	assign gap_d      = {gto_q[DIST_W-1], gto_q} - {gfrom_q[DIST_W-1], gfrom_q};

	// times 1000 as 1024 - 32 + 8
	assign lx      = DIV_W'(len_q);
	assign ix      = DIV_W'(inside_q);
	assign l1000   = (lx << 10) - (lx << 5) + (lx << 3);
	assign den     = (ix << 10) - (ix << 5) + (ix << 3);
	assign num_pos = l1000 > ix;
	assign med_dvd = l1000 - ix + den - DIV_W'(1);

	assign smp_sat = (div_rsp.quot > DIV_W'(SMP_MAX)) ? SMP_MAX : div_rsp.quot[SMP_W-1:0];
	assign spc_sat = (div_rsp.quot > DIV_W'(SPC_MAX)) ? SPC_MAX : div_rsp.quot[SPC_W-1:0];

	always_comb begin
		if (div_rsp.quot > DIV_W'(grid_q)) begin
			inside_new = grid_q;
		end else if (div_rsp.quot == '0) begin
			inside_new = SPC_W'(1);
		end else begin
			inside_new = div_rsp.quot[SPC_W-1:0];
		end
	end

	// sequencer: next state and divider requests
	always_comb begin
		state_d = state_q;
		ret_d   = S_FIN;
		div_req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (in_ok) begin
						state_d = S_INS;
					end else if (intv.last_interval) begin
						state_d = S_GRID;
					end
				end
			end
			S_INS: begin
				if (!ins_shift) begin
					state_d = pend_last_q ? S_GRID : S_IDLE;
				end
			end
			S_GRID: begin
				div_req = '{start: 1'b1, dividend: DIV_W'(maxd_q), divisor: DIV_W'(n_eff)};
				state_d = S_GRID_W;
			end
			S_GRID_W: begin
				if (div_rsp.done) begin
					if (div_rsp.quot == '0) begin
						state_d = S_EMIT;
					end else if (live_q == '0) begin
						state_d = S_AFTER;
					end else begin
						state_d = S_SX;
					end
				end
			end
			S_SX: begin
				if (amb_q) begin
					div_req = '{start: 1'b1, dividend: DIV_W'(x_mag), divisor: DIV_W'(grid_q)};
					state_d = S_SX_W;
				end else begin
					state_d = S_MERGE;
				end
			end
			S_SX_W: begin
				if (div_rsp.done) begin
					state_d = S_SY;
				end
			end
			S_SY: begin
				div_req = '{start: 1'b1, dividend: DIV_W'(y_mag), divisor: DIV_W'(grid_q)};
				state_d = S_SY_W;
			end
			S_SY_W: begin
				if (div_rsp.done) begin
					state_d = S_MERGE;
				end
			end
			S_MERGE: begin
				state_d = (i_q + 1'b1 == live_q) ? S_AFTER : S_SX;
			end
			S_AFTER: begin
				state_d = (mc_q == '0) ? S_EMIT : S_TOT;
			end
			S_TOT: begin
				div_req = '{start: 1'b1, dividend: DIV_W'(total_q), divisor: DIV_W'(n_eff)};
				state_d = S_TOT_W;
			end
			S_TOT_W: begin
				if (div_rsp.done) begin
					state_d = S_SEG;
				end
			end
			S_SEG: begin
				state_d = gap_before ? S_GC : S_MED;
			end
			S_GC: begin
				div_req = '{start: 1'b1,
				            dividend: DIV_W'({gap_d, 1'b0}) + DIV_W'(grid_q),
				            divisor: DIV_W'({grid_q, 1'b0})};
				state_d = S_GC_W;
			end
			S_GC_W: begin
				if (div_rsp.done) begin
					if (div_rsp.quot == '0) begin
						state_d = gfinal_q ? S_FIN : S_MED;
					end else begin
						state_d = S_GS;
					end
				end
			end
			S_GS: begin
				div_req = '{start: 1'b1, dividend: DIV_W'(gap_d), divisor: DIV_W'(smp_q)};
				state_d = S_GS_W;
			end
			S_GS_W: begin
				if (div_rsp.done) begin
					ret_d   = gfinal_q ? S_FIN : S_MED;
					state_d = S_EMIT;
				end
			end
			S_MED: begin
				if (num_pos) begin
					div_req = '{start: 1'b1, dividend: med_dvd, divisor: den};
					state_d = S_MED_W;
				end else begin
					state_d = S_MS;
				end
			end
			S_MED_W: begin
				if (div_rsp.done) begin
					state_d = S_MS;
				end
			end
			S_MS: begin
				div_req = '{start: 1'b1, dividend: DIV_W'(len_q), divisor: DIV_W'(smp_q)};
				state_d = S_MS_W;
			end
			S_MS_W: begin
				if (div_rsp.done) begin
					ret_d   = S_NEXT;
					state_d = S_EMIT;
				end
			end
			S_NEXT: begin
				if (i_q + 1'b1 != mc_q) begin
					state_d = S_SEG;
				end else if (fin_gap) begin
					state_d = S_GC;
				end else begin
					state_d = S_FIN;
				end
			end
			S_EMIT: begin
				if (!pend_v_q || out_free) begin
					state_d = ret_q;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			live_q   <= '0;
			mc_q     <= '0;
			i_q      <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			maxd_q   <= '0;
			steps_q  <= SMP_W'(1);
			amb_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_MAX_DIST: maxd_q  <= cfg_data;
					CFG_STEPS:    steps_q <= cfg_data[SMP_W-1:0];
					CFG_AMBIENT:  amb_q   <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == S_INS && !ins_shift) begin
				live_q <= live_q + 1'b1;
			end
			if (state_q == S_GRID_W || state_q == S_TOT_W) begin
				i_q <= '0;
			end
			if (state_q == S_GRID_W) begin
				mc_q <= '0;
			end
			if (state_q == S_MERGE) begin
				i_q <= i_q + 1'b1;
				if (mrg_keep && !mrg_join) begin
					mc_q <= mc_q + 1'b1;
				end
			end
			if (state_q == S_NEXT) begin
				i_q <= i_q + 1'b1;
			end
			// refill the output from the pending slot, else drop it once taken
			if (state_q == S_EMIT && pend_v_q && out_free) begin
				out_v_q <= 1'b1;
			end else if (state_q == S_FIN && out_free) begin
				out_v_q <= 1'b1;
			end else if (seg.ready) begin
				out_v_q <= 1'b0;
			end
			if (state_q == S_EMIT && (!pend_v_q || out_free)) begin
				pend_v_q <= 1'b1;
			end
			if (state_q == S_FIN && out_free) begin
				pend_v_q <= 1'b0;
				live_q   <= '0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q != S_EMIT) begin
			ret_q <= ret_d;
		end
		unique case (state_q)
			S_IDLE: begin
				if (acc && in_ok) begin
					ins_x_q     <= intv.entry_dist;
					ins_y_q     <= intv.exit_dist;
					j_q         <= live_q[IDX_W-1:0];
					pend_last_q <= intv.last_interval;
				end
			end
			S_INS: begin
				if (ins_shift) begin
					ent_q[j_q] <= ent_rd;
					ext_q[j_q] <= ext_rd;
					j_q        <= j_q - 1'b1;
				end else begin
					ent_q[j_q] <= ins_x_q;
					ext_q[j_q] <= ins_y_q;
				end
			end
			S_GRID_W: begin
				if (div_rsp.done) begin
					grid_q  <= div_rsp.quot[SPC_W-1:0];
					total_q <= '0;
					res_q   <= '{seg_start: '0, spacing: '0, samples: '0, is_medium: 1'b0,
					             empty: 1'b1};
				end
			end
			S_SX: begin
				sx_q <= ent_rd;
				sy_q <= ext_rd;
			end
			S_SX_W: begin
				if (div_rsp.done) begin
					sx_q <= sx_new;
				end
			end
			S_SY_W: begin
				if (div_rsp.done) begin
					sy_q <= sy_new;
				end
			end
			S_MERGE: begin
				if (mrg_keep) begin
					if (mrg_join) begin
						if (mrg_ext) begin
							mex_q[m_idx] <= sy_q;
							total_q      <= total_q + TOT_W'(add_v);
						end
					end else begin
						mst_q[mc_q[IDX_W-1:0]] <= sx_q;
						mex_q[mc_q[IDX_W-1:0]] <= sy_q;
						total_q                <= total_q + TOT_W'(add_v);
					end
				end
			end
			S_AFTER: begin
				// no span left: ambient mode still marches the whole range on the grid
				res_q <= amb_q ?
					'{seg_start: '0, spacing: grid_q, samples: n_eff, is_medium: 1'b0,
					  empty: 1'b0} :
					'{seg_start: '0, spacing: '0, samples: '0, is_medium: 1'b0, empty: 1'b1};
			end
			S_TOT_W: begin
				if (div_rsp.done) begin
					inside_q <= inside_new;
					cursor_q <= '0;
				end
			end
			S_SEG: begin
				msx_q    <= mst_rd;
				msy_q    <= mex_rd;
				len_q    <= {mex_rd[DIST_W-1], mex_rd} - {mst_rd[DIST_W-1], mst_rd};
				gfrom_q  <= cursor_q;
				gto_q    <= mst_rd;
				gfinal_q <= 1'b0;
			end
			S_GC_W: begin
				if (div_rsp.done) begin
					smp_q <= smp_sat;
				end
			end
			S_GS_W: begin
				if (div_rsp.done) begin
					res_q <= '{seg_start: gfrom_q, spacing: spc_sat, samples: smp_q,
					           is_medium: 1'b0, empty: 1'b0};
				end
			end
			S_MED: begin
				if (!num_pos) begin
					smp_q <= SMP_W'(1);
				end
			end
			S_MED_W: begin
				if (div_rsp.done) begin
					smp_q <= (div_rsp.quot == '0) ? SMP_W'(1) : smp_sat;
				end
			end
			S_MS_W: begin
				if (div_rsp.done) begin
					res_q <= '{seg_start: msx_q, spacing: spc_sat, samples: smp_q,
					           is_medium: 1'b1, empty: 1'b0};
				end
			end
			S_NEXT: begin
				// advance the cursor and prepare the closing gap
				cursor_q <= msy_q;
				gfrom_q  <= msy_q;
				gto_q    <= $signed({1'b0, maxd_q});
				gfinal_q <= 1'b1;
			end
			S_EMIT: begin
				// hold one result back so the final one can carry last_segment
				if (!pend_v_q || out_free) begin
					pend_q <= res_q;
					if (pend_v_q) begin
						out_q      <= pend_q;
						out_last_q <= 1'b0;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_q      <= pend_q;
					out_last_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign intv.ready         = (state_q == S_IDLE);
	assign seg.valid          = out_v_q;
	assign seg.seg_start      = out_q.seg_start;
	assign seg.seg_spacing    = out_q.spacing;
	assign seg.seg_samples    = out_q.samples;
	assign seg.in_medium      = out_q.is_medium;
	assign seg.empty_schedule = out_q.empty;
	assign seg.last_segment   = out_last_q;

`ifndef NO_ASSERTIONS
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		seg.valid && seg.empty_schedule |-> seg.last_segment)
		else $error("empty schedule result without last_segment");

	a_samples_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		seg.valid && !seg.empty_schedule |-> seg.seg_samples != '0)
		else $error("segment with zero samples");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_GRID_W || state_q == S_SX_W || state_q == S_SY_W ||
		                  state_q == S_TOT_W || state_q == S_GC_W || state_q == S_GS_W ||
		                  state_q == S_MED_W || state_q == S_MS_W))
		else $error("divider finished outside a wait state");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CNT_W'(MAX_INTERVALS))
		else $error("interval count beyond store depth");

	a_fin_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |-> pend_v_q)
		else $error("schedule closed with no pending result");
`endif

endmodule
`default_nettype wire
